// ----- design/mpd_pkg.sv -----
`timescale 1ns / 1ps

package mpd_pkg;

   // widths of the stream fields
   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned RLEN_W    = 28;
   localparam int unsigned MAXSIZE_W = 29;
   localparam int unsigned CNT_W     = 3;

   // remaining-length varint encoding
   localparam int unsigned CONT_BIT_POS = 7;
   localparam int unsigned DIGIT_W      = 7;
   localparam logic [CNT_W-1:0] MAX_LEN_BYTES = 3'd4;

   // maximum packet size after reset
   localparam logic [MAXSIZE_W-1:0] MAX_SIZE_RESET = 29'd1024;

   // parser phase, one-hot
   typedef enum logic [4:0] {
      PH_TYPE    = 5'b00001,
      PH_LENGTH  = 5'b00010,
      PH_DELIVER = 5'b00100,
      PH_SKIP    = 5'b01000,
      PH_ERROR   = 5'b10000
   } phase_type;

   // tag given to every byte
   typedef enum logic [2:0] {
      KIND_TYPE    = 3'd0,
      KIND_LENGTH  = 3'd1,
      KIND_DELIVER = 3'd2,
      KIND_SKIP    = 3'd3,
      KIND_ERROR   = 3'd4
   } kind_type;

   // one tagged byte on its way to the result register
   typedef struct packed {
      logic              oversize;
      logic              bad_length;
      logic              packet_last;
      kind_type          kind;
      logic [RLEN_W-1:0] remaining_length;
      logic [BYTE_W-1:0] data;
   } result_type;

endpackage

// ----- design/mqtt_packet_deframer.sv -----
`timescale 1ns / 1ps

// Tags an MQTT byte stream one byte per clock cycle while rsp_tready is high,
// with no bubbles between bytes. Each accepted byte comes out as one result
// transaction, after passing an input register and a result register; both
// stages hold under back-pressure, so throughput stays at one byte per cycle
// as long as rsp_tready is high. The result carries the byte, its kind (type,
// length, delivered payload, skipped payload, discarded), the packet end on
// tlast, and the decoded remaining length. Packets longer in total than the
// max packet size register (reset 1024) are passed with their payload tagged
// as skipped. A fourth length byte with its continuation bit set flags
// bad_length, and every later byte is tagged discarded until reset. Write
// csr_wdata only while no transaction is in flight.
module mqtt_packet_deframer (
   input  logic        clock,
   input  logic        reset,
   // configuration: max packet size
   input  logic        csr_wen,
   input  logic [28:0] csr_wdata,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [7:0] byte_out, [35:8] remaining_length, rest zero
   output logic [4:0]  rsp_tuser,   // [2:0] byte_kind, [3] bad_length, [4] oversize
   output logic        rsp_tlast    // packet_last
);

   logic                advance;
   logic                byte_fire;
   logic [7:0]          byte_data;
   mpd_pkg::result_type result;

   // input byte register
   mpd_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .advance    (advance),
      .byte_fire  (byte_fire),
      .byte_data  (byte_data)
   );

   // framing state and byte tagging
   mpd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_wdata (csr_wdata),
      .byte_fire (byte_fire),
      .byte_data (byte_data),
      .result    (result)
   );

   // result register
   mpd_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (byte_fire),
      .result     (result),
      .advance    (advance),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef SYNTHESIS
   // once a discarded byte is delivered, every later byte is discarded too
   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && (rsp_tuser[2:0] == mpd_pkg::KIND_ERROR)
      |=> !rsp_tvalid || (rsp_tuser[2:0] == mpd_pkg::KIND_ERROR))
      else $error("non-discarded byte after error lock");

   // discarded bytes carry no length
   a_error_no_length: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[2:0] == mpd_pkg::KIND_ERROR)
      |-> (rsp_tdata[35:8] == '0) && !rsp_tlast)
      else $error("discarded byte with length or packet end");

   // a packet ends only on a length or payload byte
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast
      |-> (rsp_tuser[2:0] == mpd_pkg::KIND_LENGTH)
          || (rsp_tuser[2:0] == mpd_pkg::KIND_DELIVER)
          || (rsp_tuser[2:0] == mpd_pkg::KIND_SKIP))
      else $error("packet end on a type or discarded byte");
`endif

endmodule

// ----- design/mpd_in_reg.sv -----
`timescale 1ns / 1ps

module mpd_in_reg (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [mpd_pkg::BYTE_W-1:0] req_tdata,
   input  logic                       advance,
   output logic                       byte_fire,
   output logic [mpd_pkg::BYTE_W-1:0] byte_data
);

   logic                       valid_ff;
   logic                       valid_in;
   logic [mpd_pkg::BYTE_W-1:0] data_ff;

   // room when empty or when the held byte moves on this cycle
   assign req_tready = !valid_ff || advance;
   assign byte_fire  = valid_ff && advance;
   assign byte_data  = data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (req_tready) begin
         valid_in = req_tvalid;
      end
   end

   // valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // byte holding register
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         data_ff <= req_tdata;
      end
   end

endmodule

// ----- design/mpd_parser.sv -----
`timescale 1ns / 1ps

module mpd_parser (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wen,
   input  logic [mpd_pkg::MAXSIZE_W-1:0] csr_wdata,
   input  logic                          byte_fire,
   input  logic [mpd_pkg::BYTE_W-1:0]    byte_data,
   output mpd_pkg::result_type           result
);

   mpd_pkg::phase_type              phase_ff;
   mpd_pkg::phase_type              phase_in;
   logic [mpd_pkg::CNT_W-1:0]       count_ff;
   logic [mpd_pkg::CNT_W-1:0]       count_in;
   logic [mpd_pkg::RLEN_W-1:0]      decoded_ff;
   logic [mpd_pkg::RLEN_W-1:0]      decoded_in;
   logic [mpd_pkg::RLEN_W-1:0]      left_ff;
   logic [mpd_pkg::RLEN_W-1:0]      left_in;
   logic [mpd_pkg::MAXSIZE_W-1:0]   max_size_ff;

   // per-byte decode and state advance
   always_comb begin
      logic [mpd_pkg::DIGIT_W-1:0]   digit;
      logic [mpd_pkg::RLEN_W-1:0]    shifted;
      logic [mpd_pkg::RLEN_W-1:0]    merged;
      logic [mpd_pkg::CNT_W-1:0]     count_inc;
      logic [mpd_pkg::MAXSIZE_W-1:0] total;
      logic                          skip;
      logic [mpd_pkg::RLEN_W-1:0]    left_dec;

      digit     = byte_data[mpd_pkg::DIGIT_W-1:0];
      count_inc = count_ff + mpd_pkg::CNT_W'(1);
      left_dec  = (left_ff != '0) ? left_ff - mpd_pkg::RLEN_W'(1) : left_ff;

      // place the 7-bit digit by its position in the varint
      case (count_ff[1:0])
         2'd0: begin
            shifted = {21'b0, digit};
         end
         2'd1: begin
            shifted = {14'b0, digit, 7'b0};
         end
         2'd2: begin
            shifted = {7'b0, digit, 14'b0};
         end
         default: begin
            shifted = {digit, 21'b0};
         end
      endcase
      merged = decoded_ff | shifted;
      total  = mpd_pkg::MAXSIZE_W'(1) + mpd_pkg::MAXSIZE_W'(count_inc)
               + {1'b0, merged};
      skip   = total > max_size_ff;

      phase_in   = phase_ff;
      count_in   = count_ff;
      decoded_in = decoded_ff;
      left_in    = left_ff;

      result.data             = byte_data;
      result.kind             = mpd_pkg::KIND_ERROR;
      result.packet_last      = 1'b0;
      result.bad_length       = 1'b0;
      result.oversize         = 1'b0;
      result.remaining_length = '0;

      case (phase_ff)
         mpd_pkg::PH_TYPE: begin
            result.kind = mpd_pkg::KIND_TYPE;
            phase_in    = mpd_pkg::PH_LENGTH;
            count_in    = '0;
            decoded_in  = '0;
            left_in     = '0;
         end
         mpd_pkg::PH_LENGTH: begin
            result.kind = mpd_pkg::KIND_LENGTH;
            decoded_in  = merged;
            count_in    = count_inc;
            if (!byte_data[mpd_pkg::CONT_BIT_POS]) begin
               result.remaining_length = merged;
               result.oversize         = skip;
               if (merged == '0) begin
                  // zero-length packet ends on its last length byte
                  result.packet_last = 1'b1;
                  phase_in           = mpd_pkg::PH_TYPE;
                  count_in           = '0;
                  decoded_in         = '0;
                  left_in            = '0;
               end else begin
                  left_in  = merged;
                  phase_in = skip ? mpd_pkg::PH_SKIP : mpd_pkg::PH_DELIVER;
               end
            end else if (count_inc >= mpd_pkg::MAX_LEN_BYTES) begin
               // continuation on the fourth length byte locks the parser
               result.bad_length = 1'b1;
               phase_in          = mpd_pkg::PH_ERROR;
               left_in           = '0;
            end
         end
         mpd_pkg::PH_DELIVER, mpd_pkg::PH_SKIP: begin
            result.kind = (phase_ff == mpd_pkg::PH_SKIP) ?
                          mpd_pkg::KIND_SKIP : mpd_pkg::KIND_DELIVER;
            result.oversize         = (phase_ff == mpd_pkg::PH_SKIP);
            result.remaining_length = decoded_ff;
            left_in                 = left_dec;
            if (left_dec == '0) begin
               result.packet_last = 1'b1;
               phase_in           = mpd_pkg::PH_TYPE;
               count_in           = '0;
               decoded_in         = '0;
            end
         end
         default: begin
            phase_in = mpd_pkg::PH_ERROR;
         end
      endcase
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= mpd_pkg::PH_TYPE;
         count_ff   <= '0;
         decoded_ff <= '0;
         left_ff    <= '0;
      end else if (byte_fire) begin
         phase_ff   <= phase_in;
         count_ff   <= count_in;
         decoded_ff <= decoded_in;
         left_ff    <= left_in;
      end
   end

   // maximum packet size register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_size_ff <= mpd_pkg::MAX_SIZE_RESET;
      end else if (csr_wen) begin
         max_size_ff <= csr_wdata;
      end
   end

endmodule

// ----- design/mpd_out_reg.sv -----
`timescale 1ns / 1ps

module mpd_out_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  mpd_pkg::result_type result,
   output logic                advance,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [39:0]         rsp_tdata,
   output logic [4:0]          rsp_tuser,
   output logic                rsp_tlast
);

   logic                valid_ff;
   logic                valid_in;
   mpd_pkg::result_type result_ff;

   // free when empty or when the held transaction leaves now
   assign advance = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   // valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // result holding register
   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {4'b0, result_ff.remaining_length, result_ff.data};
   assign rsp_tuser  = {result_ff.oversize, result_ff.bad_length, result_ff.kind};
   assign rsp_tlast  = result_ff.packet_last;

endmodule
